@@ rtl/core/omw_pkg.sv @@
// Package for the chassis wheel speed mixer: drive mode codes, register
// indexes, fixed-point constants and the sine/cosine lookup tables.
// No dependencies.
package omw_pkg;

	localparam int SINE_TABLE_DEPTH = 256;
	localparam int SINE_IDX_W = $clog2(SINE_TABLE_DEPTH);
	localparam int SPEED_WIDTH = 16;

	localparam int CMD_W = 16;
	localparam int RATIO_W = 16;
	localparam int GAIN_W = 17;
	localparam int TRIG_W = 17;

	localparam logic [RATIO_W:0] Q15_ONE = 17'd32768;
	localparam logic signed [15:0] HALF_SQRT3_Q15 = 16'sd28378;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd32768;

	localparam logic [2:0] MODE_DIFF      = 3'd0;
	localparam logic [2:0] MODE_OMNI_AT   = 3'd1;
	localparam logic [2:0] MODE_OMNI_BTW  = 3'd2;
	localparam logic [2:0] MODE_SKID      = 3'd3;
	localparam logic [2:0] MODE_MECANUM   = 3'd4;
	localparam logic [2:0] MODE_OFFCENTER = 3'd5;

	localparam logic [1:0] CFG_DRIVE_MODE = 2'd0;
	localparam logic [1:0] CFG_HEADLESS   = 2'd1;
	localparam logic [1:0] CFG_WIDTH      = 2'd2;
	localparam logic [1:0] CFG_LENGTH     = 2'd3;

	typedef logic signed [TRIG_W-1:0] trig_tbl_t [SINE_TABLE_DEPTH];

	// sine of a/(4*depth) of a turn, Q15, from a Q30 series
	function automatic logic signed [TRIG_W-1:0] sine_entry(input logic [63:0] a);
		logic [63:0] am;
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic signed [63:0] v;
		am = a % (4 * SINE_TABLE_DEPTH);
		q = am / SINE_TABLE_DEPTH;
		r = am % SINE_TABLE_DEPTH;
		if (q[0]) begin
			r = 64'(SINE_TABLE_DEPTH) - r;
		end
		x = r * HALF_PI_Q30 / SINE_TABLE_DEPTH;
		x2 = (x * x) >> 30;
		term = x;
		sum = $signed(x);
		term = ((term * x2) >> 30) / 6;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 20;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 42;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 72;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 110;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 156;
		sum = sum + $signed(term);
		v = (sum + 64'sd16384) >>> 15;
		if (q >= 2) begin
			v = -v;
		end
		return TRIG_W'(v);
	endfunction

	function automatic trig_tbl_t build_sin();
		trig_tbl_t t;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
			t[i] = sine_entry(64'(4 * i));
		end
		return t;
	endfunction

	function automatic trig_tbl_t build_cos();
		trig_tbl_t t;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
			t[i] = sine_entry(64'(4 * i + SINE_TABLE_DEPTH));
		end
		return t;
	endfunction

	localparam trig_tbl_t SIN_TBL = build_sin();
	localparam trig_tbl_t COS_TBL = build_cos();

endpackage

@@ rtl/core/omni_mecanum_wheel_speed_mixer_top.sv @@
// Top level of the chassis wheel speed mixer: six-stage datapath plus the
// off-center yaw gain square-root sequencer. Depends on omw_pkg.
//
// One velocity command may be started every cycle while busy is low; its four
// wheel speeds appear with the done strobe, for one cycle only, and cannot be
// held off. A write to width_ratio or length_ratio starts a bit-serial square
// root that recomputes the four off-center yaw gains, one result bit per cycle:
// after such a write busy stays high until all four gains are stored, and no
// command is taken meanwhile. Other writes take effect at once.
module omni_mecanum_wheel_speed_mixer_top #(
	parameter int SPEED_WIDTH = omw_pkg::SPEED_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [15:0]            vel_forward,
	input  logic signed [15:0]            vel_side,
	input  logic signed [15:0]            vel_yaw,
	input  logic [15:0]                   heading,
	output logic                          done,
	output logic signed [SPEED_WIDTH-1:0] wheel_a,
	output logic signed [SPEED_WIDTH-1:0] wheel_b,
	output logic signed [SPEED_WIDTH-1:0] wheel_c,
	output logic signed [SPEED_WIDTH-1:0] wheel_d,
	output logic                          saturated,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [15:0]                   cfg_data
);

	localparam int WQ = 52;
	localparam int PW = 33;
	localparam int GW = 34;
	localparam int QW = 35;
	localparam int KW = 51;
	localparam int SQW = 34;
	localparam logic signed [32:0] MAXV = (33'sd1 <<< (SPEED_WIDTH - 1)) - 33'sd1;
	localparam logic signed [32:0] MINV = -MAXV - 33'sd1;

	typedef enum logic [1:0] {G_IDLE, G_LOAD, G_RUN} gstate_t;

	// configuration
	logic [2:0]  drive_mode_q;
	logic        headless_q;
	logic [15:0] width_q;
	logic [15:0] length_q;
	logic        cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_mode_q <= omw_pkg::MODE_MECANUM;
			headless_q <= 1'b0;
			width_q <= 16'd16384;
			length_q <= 16'd16384;
		end else if (cfg_we) begin
			unique case (cfg_index)
				omw_pkg::CFG_DRIVE_MODE: drive_mode_q <= cfg_data[2:0];
				omw_pkg::CFG_HEADLESS:   headless_q <= cfg_data[0];
				omw_pkg::CFG_WIDTH:      width_q <= cfg_data;
				omw_pkg::CFG_LENGTH:     length_q <= cfg_data;
			endcase
		end
	end

	// off-center gain sequencer: gain g = isqrt(4 * w' * l')
	gstate_t gstate_q;
	logic [1:0] gidx_q;
	logic [4:0] gstep_q;
	logic [SQW-1:0] rem_q;
	logic [SQW-1:0] res_q;
	logic [SQW-1:0] sbit_q;
	logic [omw_pkg::GAIN_W-1:0] gain_q [4];
	logic [15:0] wn;
	logic [15:0] ln;
	logic [15:0] wsel;
	logic [15:0] lsel;
	logic [31:0] gprod;
	logic [SQW-1:0] trial;
	logic ratio_we;

	assign wn = 16'(omw_pkg::Q15_ONE - {1'b0, width_q});
	assign ln = 16'(omw_pkg::Q15_ONE - {1'b0, length_q});
	assign wsel = gidx_q[1] ? wn : width_q;
	assign lsel = gidx_q[0] ? ln : length_q;
	assign gprod = wsel * lsel;
	assign trial = res_q + sbit_q;
	assign ratio_we = cfg_we && (cfg_index == omw_pkg::CFG_WIDTH ||
		cfg_index == omw_pkg::CFG_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gstate_q <= G_IDLE;
			gidx_q <= '0;
			gstep_q <= '0;
			rem_q <= '0;
			res_q <= '0;
			sbit_q <= '0;
			for (int i = 0; i < 4; i++) begin
				gain_q[i] <= omw_pkg::GAIN_RESET;
			end
		end else if (ratio_we) begin
			gstate_q <= G_LOAD;
			gidx_q <= '0;
		end else begin
			unique case (gstate_q)
				G_IDLE: begin
				end
				G_LOAD: begin
					rem_q <= {gprod, 2'b00};
					res_q <= '0;
					sbit_q <= SQW'(1) << 32;
					gstep_q <= '0;
					gstate_q <= G_RUN;
				end
				G_RUN: begin
					if (rem_q >= trial) begin
						rem_q <= rem_q - trial;
						res_q <= (res_q >> 1) + sbit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					sbit_q <= sbit_q >> 2;
					gstep_q <= gstep_q + 5'd1;
					if (gstep_q == 5'd16) begin
						gain_q[gidx_q] <= (rem_q >= trial) ?
							omw_pkg::GAIN_W'((res_q >> 1) + sbit_q) :
							omw_pkg::GAIN_W'(res_q >> 1);
						gidx_q <= gidx_q + 2'd1;
						gstate_q <= (gidx_q == 2'd3) ? G_IDLE : G_LOAD;
					end
				end
				default: gstate_q <= G_IDLE;
			endcase
		end
	end

	assign busy = (gstate_q != G_IDLE);

	// pipeline valid bits
	logic [5:0] v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[4:0], start && !busy};
		end
	end
	assign done = v_q[5];

	// s1: capture command, table lookup
	logic signed [15:0] vx_s1, vy_s1, r_s1;
	logic signed [omw_pkg::TRIG_W-1:0] sn_s1, cs_s1;
	logic [omw_pkg::SINE_IDX_W-1:0] tidx;
	assign tidx = heading[15 -: omw_pkg::SINE_IDX_W];

	always_ff @(posedge clk) begin
		vx_s1 <= vel_forward;
		vy_s1 <= vel_side;
		r_s1 <= vel_yaw;
		sn_s1 <= omw_pkg::SIN_TBL[tidx];
		cs_s1 <= omw_pkg::COS_TBL[tidx];
	end

	// s2: rotation and yaw gain products
	logic signed [PW-1:0] xc_s2, ys_s2, yc_s2, xs_s2;
	logic signed [GW-1:0] rg_s2 [4];
	logic signed [15:0] vx_s2, vy_s2, r_s2;

	always_ff @(posedge clk) begin
		xc_s2 <= vx_s1 * cs_s1;
		ys_s2 <= vy_s1 * sn_s1;
		yc_s2 <= vy_s1 * cs_s1;
		xs_s2 <= vx_s1 * sn_s1;
		for (int i = 0; i < 4; i++) begin
			rg_s2[i] <= r_s1 * $signed({1'b0, gain_q[i]});
		end
		vx_s2 <= vx_s1;
		vy_s2 <= vy_s1;
		r_s2 <= r_s1;
	end

	// s3: Q15 translation terms
	logic signed [QW-1:0] vxq_s3, vyq_s3;
	logic signed [GW-1:0] rg_s3 [4];
	logic signed [15:0] r_s3;
	logic hl;
	assign hl = headless_q && (drive_mode_q == omw_pkg::MODE_OMNI_AT ||
		drive_mode_q == omw_pkg::MODE_OMNI_BTW || drive_mode_q == omw_pkg::MODE_MECANUM);

	always_ff @(posedge clk) begin
		if (hl) begin
			vxq_s3 <= QW'(xc_s2) + QW'(ys_s2);
			vyq_s3 <= QW'(yc_s2) - QW'(xs_s2);
		end else begin
			vxq_s3 <= QW'(vx_s2) <<< 15;
			vyq_s3 <= QW'(vy_s2) <<< 15;
		end
		rg_s3 <= rg_s2;
		r_s3 <= r_s2;
	end

	// s4: omni sqrt(3)/2 product
	logic signed [KW-1:0] kx_s4;
	logic signed [QW-1:0] vxq_s4, vyq_s4;
	logic signed [GW-1:0] rg_s4 [4];
	logic signed [15:0] r_s4;

	always_ff @(posedge clk) begin
		kx_s4 <= KW'(vxq_s3) * KW'(omw_pkg::HALF_SQRT3_Q15);
		vxq_s4 <= vxq_s3;
		vyq_s4 <= vyq_s3;
		rg_s4 <= rg_s3;
		r_s4 <= r_s3;
	end

	// s5: Q30 wheel mix
	logic signed [WQ-1:0] w_s5 [4];
	logic signed [WQ-1:0] x30, y30, pp, pm, r30, t30;
	logic signed [WQ-1:0] g30 [4];
	logic signed [WQ-1:0] wm [4];
	logic ratio_ok;

	assign x30 = WQ'(vxq_s4) <<< 15;
	assign y30 = WQ'(vyq_s4) <<< 15;
	assign pp = y30 + x30;
	assign pm = y30 - x30;
	assign r30 = WQ'(r_s4) <<< 30;
	assign t30 = (WQ'(vyq_s4) <<< 14) - WQ'(kx_s4);
	assign ratio_ok = ({1'b0, width_q} <= omw_pkg::Q15_ONE) &&
		({1'b0, length_q} <= omw_pkg::Q15_ONE);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			g30[i] = WQ'(rg_s4[i]) <<< 15;
			wm[i] = '0;
		end
		unique case (drive_mode_q)
			omw_pkg::MODE_DIFF: begin
				wm[0] = r30 - x30;
				wm[1] = x30 + r30;
			end
			omw_pkg::MODE_OMNI_AT: begin
				wm[0] = y30 + r30;
				wm[1] = r30 - t30;
				wm[2] = t30 + r30;
			end
			omw_pkg::MODE_OMNI_BTW: begin
				wm[0] = -(y30 + r30);
				wm[1] = t30 - r30;
				wm[2] = -(t30 + r30);
			end
			omw_pkg::MODE_SKID: begin
				wm[0] = r30 - x30;
				wm[1] = r30 - x30;
				wm[2] = x30 + r30;
				wm[3] = x30 + r30;
			end
			omw_pkg::MODE_MECANUM: begin
				wm[0] = pp + r30;
				wm[1] = r30 - pm;
				wm[2] = pm + r30;
				wm[3] = r30 - pp;
			end
			omw_pkg::MODE_OFFCENTER: begin
				if (ratio_ok) begin
					wm[0] = pp + g30[0];
					wm[1] = g30[1] - pm;
					wm[2] = pm + g30[2];
					wm[3] = g30[3] - pp;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		w_s5 <= wm;
	end

	// s6: round half up, saturate
	logic signed [WQ-1:0] wr [4];
	logic signed [32:0] rv [4];
	logic [SPEED_WIDTH-1:0] ws [4];
	logic [3:0] sat;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			wr[i] = w_s5[i] + (WQ'(1) <<< 29);
			rv[i] = 33'($signed(wr[i][WQ-1:30]));
			sat[i] = 1'b0;
			if (rv[i] > MAXV) begin
				ws[i] = SPEED_WIDTH'(MAXV);
				sat[i] = 1'b1;
			end else if (rv[i] < MINV) begin
				ws[i] = SPEED_WIDTH'(MINV);
				sat[i] = 1'b1;
			end else begin
				ws[i] = SPEED_WIDTH'(rv[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		wheel_a <= ws[0];
		wheel_b <= ws[1];
		wheel_c <= ws[2];
		wheel_d <= ws[3];
		saturated <= |sat;
	end

endmodule
